FILE: hdl/assert_macros.svh
// Assertion macros shared by the tracker RTL.
// Depends on nothing; each user has clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every clock edge outside reset.
`define DSST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that cond is followed in the next cycle by nxt.
`define DSST_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

FILE: hdl/dsst_pkg.sv
// Package for the dirty stripe shard tracker: widths, codes and the
// divider request/response types. Depends on nothing.
package dsst_pkg;

  localparam int STRIPE_ENTRIES_DEF = 1024;
  localparam int MAX_SHARDS_DEF     = 16;

  localparam int OFF_W   = 48;
  localparam int LEN_W   = 32;
  localparam int QRY_W   = 32;
  localparam int K_W     = 5;
  localparam int SB_W    = 25;
  localparam int CFG_W   = 25;
  localparam int CFGI_W  = 2;
  localparam int STAT_W  = 2;
  localparam int SCNT_W  = 11;
  localparam int DVD_W   = 49;  // offset + count - 1 needs one bit over offset
  localparam int SS_W    = 30;  // k * shard_bytes
  localparam int QUO_W   = 17;
  localparam int ITER_W  = 5;
  localparam int SHIFT_W = 6;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_BEYOND  = 2'd2;

  localparam logic [CFGI_W-1:0] CFG_GEOM  = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_K     = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_SBYTE = 2'd2;

  localparam logic CMD_MARK  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [SS_W-1:0]   divisor;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
    logic [SS_W-1:0]  remainder;
  } div_rsp_t;

endpackage

FILE: hdl/dsst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module dsst_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/dsst_div.sv
// Shared restoring divider, one quotient bit per cycle, short quotients only.
// Depends on dsst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dsst_div (
  input  logic              clk,
  input  logic              rst_n,
  input  dsst_pkg::div_req_t req,
  output dsst_pkg::div_rsp_t rsp
);

  logic [dsst_pkg::DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [dsst_pkg::SS_W-1:0]   rem_r, rem_nxt;
  logic [dsst_pkg::SS_W-1:0]   dvs_r, dvs_nxt;
  logic [dsst_pkg::QUO_W-1:0]  quo_r, quo_nxt;
  logic [dsst_pkg::ITER_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [dsst_pkg::SS_W:0]     rem_sh;
  logic                        ge;

  // Partial remainder shifted by one dividend bit, then trial subtract.
  assign rem_sh = {rem_r, dvd_r[dsst_pkg::DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      // Bits above the quotient width are already below the divisor.
      dvd_nxt  = req.dividend << (dsst_pkg::SHIFT_W'(dsst_pkg::DVD_W) -
                                  dsst_pkg::SHIFT_W'(req.iters));
      rem_nxt  = dsst_pkg::SS_W'(req.dividend >> req.iters);
      dvs_nxt  = req.divisor;
      quo_nxt  = '0;
      cnt_nxt  = req.iters;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? dsst_pkg::SS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[dsst_pkg::SS_W-1:0];
      quo_nxt = {quo_r[dsst_pkg::QUO_W-2:0], ge};
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == dsst_pkg::ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

  `DSST_ASSERT(a_no_start_busy, !(req.start && busy_r), "divider restarted while busy")
  `DSST_ASSERT_NEXT(a_last_step, busy_r && cnt_r == dsst_pkg::ITER_W'(1) && !req.start, done_r && !busy_r, "divider missed its done")

endmodule

FILE: hdl/dirty_stripe_shard_tracker.sv
// Top level of the dirty stripe shard tracker: sequencer, entry table and
// shared divider. Depends on dsst_pkg, dsst_ram, dsst_div, assert_macros.svh.
`include "assert_macros.svh"

// The block keeps one entry per stripe (present, fully dirty, shard mask)
// in a RAM of STRIPE_ENTRIES words. After reset it runs a clearing pass,
// one entry a cycle, with in_ready low; config writes are taken during
// that time. One beat is handled at a time. A query steps through the
// table read (S_QRD) and the result (S_QRES) to the result beat; an
// invalid mark goes straight to the result beat, and a mark beyond the
// table passes S_MUL, S_LIM and S_CHK first. A good mark runs four
// divisions on the single shared divider, then a read (S_RD) and a write
// (S_WR) per touched stripe, a read-modify-write on the one table port.
module dirty_stripe_shard_tracker #(
  parameter int STRIPE_ENTRIES = dsst_pkg::STRIPE_ENTRIES_DEF,
  parameter int MAX_SHARDS     = dsst_pkg::MAX_SHARDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic [dsst_pkg::OFF_W-1:0]  in_offset,
  input  logic [dsst_pkg::LEN_W-1:0]  in_count,
  input  logic [dsst_pkg::QRY_W-1:0]  in_query_stripe,
  input  logic [dsst_pkg::QRY_W-1:0]  in_query_shard,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dsst_pkg::STAT_W-1:0] out_status,
  output logic                        out_present,
  output logic                        out_fully_dirty,
  output logic                        out_shard_dirty,
  output logic [dsst_pkg::SCNT_W-1:0] out_stripe_count,
  input  logic                        cfg_we,
  input  logic [dsst_pkg::CFGI_W-1:0] cfg_index,
  input  logic [dsst_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int IDX_W = $clog2(STRIPE_ENTRIES);
  localparam int SH_W  = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;
  localparam int ENT_W = MAX_SHARDS + 2;
  localparam int CNT_W = $clog2(STRIPE_ENTRIES + 1);
  localparam int LIM_W = dsst_pkg::SS_W + IDX_W + 1;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_LIM  = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_DV0  = 4'd5;
  localparam logic [3:0] S_DV1  = 4'd6;
  localparam logic [3:0] S_DV2  = 4'd7;
  localparam logic [3:0] S_DV3  = 4'd8;
  localparam logic [3:0] S_RD   = 4'd9;
  localparam logic [3:0] S_WR   = 4'd10;
  localparam logic [3:0] S_QRD  = 4'd11;
  localparam logic [3:0] S_QRES = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  // Config registers.
  logic                      geom_r;
  logic [dsst_pkg::K_W-1:0]  k_r;
  logic [dsst_pkg::SB_W-1:0] sb_r;

  // Sequencer and latched beat.
  logic [3:0]                 state_r, state_nxt;
  logic                       cmd_r;
  logic [dsst_pkg::OFF_W-1:0] off_r;
  logic [dsst_pkg::LEN_W-1:0] len_r;
  logic [dsst_pkg::QRY_W-1:0] qs_r;
  logic [dsst_pkg::QRY_W-1:0] qsh_r;
  logic [dsst_pkg::DVD_W-1:0] end_m1_r;
  logic [dsst_pkg::SS_W-1:0]  ss_r;
  logic [LIM_W-1:0]           lim_r;
  logic [IDX_W-1:0]           first_r, last_r, s_r, s_nxt;
  logic [dsst_pkg::SS_W-1:0]  rem_first_r, rem_last_r;
  logic [SH_W-1:0]            fs_first_r, ls_last_r;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;

  // Pending result.
  logic [dsst_pkg::STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic                        res_pres_r, res_pres_nxt;
  logic                        res_full_r, res_full_nxt;
  logic                        res_sd_r, res_sd_nxt;

  // Output register.
  logic                        out_valid_r;
  logic [dsst_pkg::STAT_W-1:0] out_stat_r;
  logic                        out_pres_r, out_full_r, out_sd_r;
  logic [dsst_pkg::SCNT_W-1:0] out_cnt_r;

  dsst_pkg::div_req_t div_req;
  dsst_pkg::div_rsp_t div_rsp;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  logic                  accept;
  logic                  bad_mark;
  logic                  q_in_table;
  logic                  ent_valid, ent_full;
  logic [MAX_SHARDS-1:0] ent_mask, full_mask, rng_mask, new_mask;
  logic [SH_W-1:0]       fs, ls;
  logic                  new_full;

  assign accept = in_valid && in_ready;

  // Invalid geometry or empty write.
  assign bad_mark = (in_count == '0) || !geom_r || (k_r == '0) ||
                    (32'(k_r) > 32'(MAX_SHARDS)) || (sb_r == '0);
  assign q_in_table = in_query_stripe < dsst_pkg::QRY_W'(STRIPE_ENTRIES);

  assign ent_valid = ram_rdata[ENT_W-1];
  assign ent_full  = ram_rdata[ENT_W-2];
  assign ent_mask  = ram_rdata[MAX_SHARDS-1:0];

  // Shard span inside the current stripe: partial at the ends, whole between.
  assign fs        = (s_r == first_r) ? fs_first_r : '0;
  assign ls        = (s_r == last_r) ? ls_last_r : SH_W'(k_r - 1'b1);
  assign rng_mask  = ({MAX_SHARDS{1'b1}} << fs) &
                     ({MAX_SHARDS{1'b1}} >> (SH_W'(MAX_SHARDS - 1) - ls));
  assign full_mask = ~({MAX_SHARDS{1'b1}} << k_r);
  assign new_mask  = (ent_valid ? ent_mask : '0) | rng_mask;
  assign new_full  = (new_mask & full_mask) == full_mask;

  always_comb begin
    state_nxt    = state_r;
    s_nxt        = s_r;
    cnt_nxt      = cnt_r;
    res_stat_nxt = res_stat_r;
    res_pres_nxt = res_pres_r;
    res_full_nxt = res_full_r;
    res_sd_nxt   = res_sd_r;
    ram_we       = 1'b0;
    ram_waddr    = s_r;
    ram_wdata    = '0;
    ram_raddr    = (state_r == S_QRD) ? qs_r[IDX_W-1:0] : s_r;
    div_req      = '0;
    unique case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        s_nxt  = s_r + 1'b1;
        if (s_r == IDX_W'(STRIPE_ENTRIES - 1)) begin
          s_nxt     = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_stat_nxt = dsst_pkg::ST_OK;
          res_pres_nxt = 1'b0;
          res_full_nxt = 1'b0;
          res_sd_nxt   = 1'b0;
          if (in_cmd == dsst_pkg::CMD_QUERY) begin
            state_nxt = q_in_table ? S_QRD : S_FIN;
          end else if (bad_mark) begin
            res_stat_nxt = dsst_pkg::ST_INVALID;
            state_nxt    = S_FIN;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: state_nxt = S_LIM;
      S_LIM: state_nxt = S_CHK;
      S_CHK: begin
        // Reject the whole range when its last byte lies past the table.
        if (end_m1_r >= dsst_pkg::DVD_W'(lim_r)) begin
          res_stat_nxt = dsst_pkg::ST_BEYOND;
          state_nxt    = S_FIN;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = dsst_pkg::DVD_W'(off_r);
          div_req.divisor  = ss_r;
          div_req.iters    = dsst_pkg::ITER_W'(IDX_W);
          state_nxt        = S_DV0;
        end
      end
      S_DV0: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = end_m1_r;
          div_req.divisor  = ss_r;
          div_req.iters    = dsst_pkg::ITER_W'(IDX_W);
          state_nxt        = S_DV1;
        end
      end
      S_DV1: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = dsst_pkg::DVD_W'(rem_first_r);
          div_req.divisor  = dsst_pkg::SS_W'(sb_r);
          div_req.iters    = dsst_pkg::ITER_W'(SH_W);
          state_nxt        = S_DV2;
        end
      end
      S_DV2: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = dsst_pkg::DVD_W'(rem_last_r);
          div_req.divisor  = dsst_pkg::SS_W'(sb_r);
          div_req.iters    = dsst_pkg::ITER_W'(SH_W);
          state_nxt        = S_DV3;
        end
      end
      S_DV3: begin
        if (div_rsp.done) begin
          s_nxt     = first_r;
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_WR;
      S_WR: begin
        // Leave a fully dirty entry alone; otherwise merge and promote.
        if (!(ent_valid && ent_full)) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b1, new_full, new_mask};
        end
        if (!ent_valid) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (s_r == last_r) begin
          state_nxt = S_FIN;
        end else begin
          s_nxt     = s_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_QRD: state_nxt = S_QRES;
      S_QRES: begin
        res_pres_nxt = ent_valid;
        res_full_nxt = ent_valid && ent_full;
        if (ent_valid && ent_full) begin
          res_sd_nxt = 1'b1;
        end else if (ent_valid && (qsh_r < dsst_pkg::QRY_W'(k_r)) &&
                     (qsh_r < dsst_pkg::QRY_W'(MAX_SHARDS))) begin
          res_sd_nxt = ent_mask[qsh_r[SH_W-1:0]];
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      s_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      geom_r      <= 1'b0;
      k_r         <= dsst_pkg::K_W'(4);
      sb_r        <= dsst_pkg::SB_W'(1);
    end else begin
      state_r <= state_nxt;
      s_r     <= s_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          dsst_pkg::CFG_GEOM:  geom_r <= cfg_wdata[0];
          dsst_pkg::CFG_K:     k_r    <= cfg_wdata[dsst_pkg::K_W-1:0];
          dsst_pkg::CFG_SBYTE: sb_r   <= cfg_wdata[dsst_pkg::SB_W-1:0];
          default: ;
        endcase
      end
      // Hand the result to the output register once it is free.
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    res_stat_r <= res_stat_nxt;
    res_pres_r <= res_pres_nxt;
    res_full_r <= res_full_nxt;
    res_sd_r   <= res_sd_nxt;
    if (accept) begin
      cmd_r <= in_cmd;
      off_r <= in_offset;
      len_r <= in_count;
      qs_r  <= in_query_stripe;
      qsh_r <= in_query_shard;
    end
    if (state_r == S_MUL) begin
      ss_r     <= dsst_pkg::SS_W'(dsst_pkg::SS_W'(k_r) * dsst_pkg::SS_W'(sb_r));
      end_m1_r <= dsst_pkg::DVD_W'(off_r) + dsst_pkg::DVD_W'(len_r) - 1'b1;
    end
    if (state_r == S_LIM) begin
      lim_r <= LIM_W'(ss_r) * LIM_W'(STRIPE_ENTRIES);
    end
    if (state_r == S_DV0 && div_rsp.done) begin
      first_r     <= div_rsp.quotient[IDX_W-1:0];
      rem_first_r <= div_rsp.remainder;
    end
    if (state_r == S_DV1 && div_rsp.done) begin
      last_r     <= div_rsp.quotient[IDX_W-1:0];
      rem_last_r <= div_rsp.remainder;
    end
    if (state_r == S_DV2 && div_rsp.done) begin
      fs_first_r <= div_rsp.quotient[SH_W-1:0];
    end
    if (state_r == S_DV3 && div_rsp.done) begin
      ls_last_r <= div_rsp.quotient[SH_W-1:0];
    end
    if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
      out_stat_r <= res_stat_r;
      out_pres_r <= res_pres_r && (cmd_r == dsst_pkg::CMD_QUERY);
      out_full_r <= res_full_r;
      out_sd_r   <= res_sd_r;
      out_cnt_r  <= dsst_pkg::SCNT_W'(cnt_r);
    end
  end

  dsst_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  dsst_ram #(
    .WIDTH (ENT_W),
    .DEPTH (STRIPE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_stat_r;
  assign out_present      = out_pres_r;
  assign out_fully_dirty  = out_full_r;
  assign out_shard_dirty  = out_sd_r;
  assign out_stripe_count = out_cnt_r;

  `DSST_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(STRIPE_ENTRIES), "present count past table size")
  `DSST_ASSERT(a_walk_range, (state_r != S_WR) || (s_r >= first_r && s_r <= last_r), "walk left the marked stripe range")
  `DSST_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "accepted a beat without leaving idle")

endmodule
